// ----- hdl/mvt_pkg.sv -----
// Package for the 4x4 matrix-vector transform engine.
// Holds the field widths, the payload structs, the register index codes and the
// pipeline stage numbering. Every other file depends on it.
package mvt_pkg;

  localparam int MAX_DIM        = 4;
  localparam int DIM_DEF        = 4;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FIELD_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // 1.0 in Q16.16; narrower data widths keep its low bits.
  localparam logic [FIELD_W-1:0] UNIT_COEF = 32'h0001_0000;

  // Pipeline stages, numbered from the input side.
  localparam int STG_MUL    = 0;
  localparam int STG_PAIR   = 1;
  localparam int STG_SUM    = 2;
  localparam int STG_SAT    = 3;
  localparam int STG_OUT    = 4;
  localparam int NUM_STAGES = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 4'd0,
    REG_ROW0_COLS23 = 4'd1,
    REG_ROW1_COLS01 = 4'd2,
    REG_ROW1_COLS23 = 4'd3,
    REG_ROW2_COLS01 = 4'd4,
    REG_ROW2_COLS23 = 4'd5,
    REG_ROW3_COLS01 = 4'd6,
    REG_ROW3_COLS23 = 4'd7
  } cfg_reg_t;

  // Register holding a coefficient, by row and by column pair.
  localparam cfg_reg_t COEF_REG [MAX_DIM][2] = '{
    '{REG_ROW0_COLS01, REG_ROW0_COLS23},
    '{REG_ROW1_COLS01, REG_ROW1_COLS23},
    '{REG_ROW2_COLS01, REG_ROW2_COLS23},
    '{REG_ROW3_COLS01, REG_ROW3_COLS23}
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_w;
    logic signed [FIELD_W-1:0] vec_z;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_x;
  } vec_t;

  typedef struct packed {
    logic                      overflow;
    logic signed [FIELD_W-1:0] out_w;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_x;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  // Load enables of the pipeline stages, one per stage.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } ctrl_t;

endpackage

// ----- hdl/mvt_if.sv -----
// Handshake channels of the transform engine: input vectors, results and
// configuration writes. Depends on mvt_pkg for the payload types.
interface mvt_vec_if;
  logic          valid;
  logic          ready;
  mvt_pkg::vec_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mvt_res_if;
  logic          valid;
  logic          ready;
  mvt_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mvt_cfg_if;
  logic          valid;
  logic          ready;
  mvt_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mvt_cfg.sv -----
// Coefficient register file of the transform engine.
// Unpacks 64-bit register writes into signed coefficients; uses mvt_pkg and mvt_if.
module mvt_cfg #(
  parameter int DIM        = mvt_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  mvt_cfg_if.sink                                cfg,
  output logic [DIM-1:0][DIM-1:0][DATA_WIDTH-1:0] coef
);

  localparam int HALF_W = mvt_pkg::CFG_DATA_W / 2;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid && cfg.ready;

  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      // Even columns sit in the low half of their register, odd ones in the high half.
      always_ff @(posedge clk) begin
        if (rst) begin
          coef[r][c] <= (r == c) ? mvt_pkg::UNIT_COEF[DATA_WIDTH-1:0] : '0;
        end else if (wr && cfg.data.index == mvt_pkg::COEF_REG[r][c >> 1]) begin
          coef[r][c] <= cfg.data.wdata[(c & 1) * HALF_W +: DATA_WIDTH];
        end
      end
    end
  end

endmodule

// ----- hdl/mvt_lane.sv -----
// One row of the transform: multiply, pairwise add, final add with rounding,
// then rescale and saturate. Four registered stages; uses mvt_pkg.
module mvt_lane #(
  parameter int DIM        = mvt_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  mvt_pkg::ctrl_t                  ctrl,
  input  logic [DIM-1:0][DATA_WIDTH-1:0]  coef_row,
  input  logic [DIM-1:0][DATA_WIDTH-1:0]  vec,
  output logic [DATA_WIDTH-1:0]           res,
  output logic                            ovf
);

  localparam int PW    = 2 * DATA_WIDTH;
  localparam int NPAIR = (DIM + 1) / 2;
  localparam int SW    = PW + 2;

  localparam logic signed [SW-1:0] ROUND   = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PW-1:0] prod   [DIM];
  logic signed [PW:0]   pair_d [NPAIR];
  logic signed [PW:0]   pair   [NPAIR];
  logic signed [SW-1:0] sum_d;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;

  always_ff @(posedge clk) begin
    if (ctrl.load[mvt_pkg::STG_MUL]) begin
      for (int j = 0; j < DIM; j++) begin
        prod[j] <= PW'($signed(coef_row[j])) * PW'($signed(vec[j]));
      end
    end
  end

  for (genvar p = 0; p < NPAIR; p++) begin : g_pair
    if (2 * p + 1 < DIM) begin : g_two
      assign pair_d[p] = (PW+1)'(prod[2*p]) + (PW+1)'(prod[2*p+1]);
    end else begin : g_one
      assign pair_d[p] = (PW+1)'(prod[2*p]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[mvt_pkg::STG_PAIR]) begin
      for (int p = 0; p < NPAIR; p++) begin
        pair[p] <= pair_d[p];
      end
    end
  end

  always_comb begin
    sum_d = ROUND;
    for (int p = 0; p < NPAIR; p++) begin
      sum_d = sum_d + SW'(pair[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[mvt_pkg::STG_SUM]) begin
      sum <= sum_d;
    end
  end

  // The arithmetic shift floors, so with the half added before it rounds half up.
  assign shifted = sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctrl.load[mvt_pkg::STG_SAT]) begin
      if (shifted > SAT_MAX) begin
        res <= SAT_MAX[DATA_WIDTH-1:0];
        ovf <= 1'b1;
      end else if (shifted < SAT_MIN) begin
        res <= SAT_MIN[DATA_WIDTH-1:0];
        ovf <= 1'b1;
      end else begin
        res <= shifted[DATA_WIDTH-1:0];
        ovf <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/mvt_merge.sv -----
// Merge stage of the transform: gathers the row results of all lanes into one
// result item, widens them to the field width and combines the overflow flags.
// Uses mvt_pkg.
module mvt_merge #(
  parameter int DIM        = mvt_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  mvt_pkg::ctrl_t                 ctrl,
  input  logic [DIM-1:0][DATA_WIDTH-1:0] lane_res,
  input  logic [DIM-1:0]                 lane_ovf,
  output mvt_pkg::res_t                  res
);

  logic [mvt_pkg::MAX_DIM-1:0][mvt_pkg::FIELD_W-1:0] comp;

  // Rows beyond the matrix size read as zero.
  for (genvar r = 0; r < mvt_pkg::MAX_DIM; r++) begin : g_comp
    if (r < DIM) begin : g_used
      assign comp[r] = mvt_pkg::FIELD_W'($signed(lane_res[r]));
    end else begin : g_unused
      assign comp[r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[mvt_pkg::STG_OUT]) begin
      res.out_x    <= comp[0];
      res.out_y    <= comp[1];
      res.out_z    <= comp[2];
      res.out_w    <= comp[3];
      res.overflow <= |lane_ovf;
    end
  end

endmodule

// ----- hdl/matrix_vector_transform_4x4.sv -----
// Top level of the 4x4 fixed-point matrix-vector transform engine.
// Path: an input goes through the multiply, pair, sum, saturate and output stage registers.
// Throughput: one vector per cycle while the output is ready; every row lane has its own
// multiplier per column and the five stages are fully pipelined, each stalling only when full.
// Reset: pipeline empty, matrix set to identity; config writes are always ready.
module matrix_vector_transform_4x4 #(
  parameter int DIM        = mvt_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  mvt_vec_if.sink   vec_in,
  mvt_res_if.source res_out,
  mvt_cfg_if.sink   cfg
);

  localparam int NS = mvt_pkg::NUM_STAGES;
  localparam int FW = mvt_pkg::FIELD_W;

  localparam logic [FW-1:0] OUT_MAX = FW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic [FW-1:0] OUT_MIN = ~OUT_MAX;

  logic [DIM-1:0][DIM-1:0][DATA_WIDTH-1:0]      coef;
  logic [mvt_pkg::MAX_DIM-1:0][FW-1:0]          in_comp;
  logic [DIM-1:0][DATA_WIDTH-1:0]               vec;
  logic [DIM-1:0][DATA_WIDTH-1:0]               lane_res;
  logic [DIM-1:0]                               lane_ovf;
  logic [NS-1:0]                                valid;
  logic [NS:0]                                  rdy;
  mvt_pkg::ctrl_t                               ctrl;

  // A stage can take new data when it is empty or its content moves on.
  always_comb begin
    rdy[NS] = res_out.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign ctrl.load     = rdy[NS-1:0];
  assign vec_in.ready  = rdy[0];
  assign res_out.valid = valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          valid[k] <= (k == 0) ? vec_in.valid : valid[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_comp = {vec_in.data.vec_w, vec_in.data.vec_z, vec_in.data.vec_y, vec_in.data.vec_x};

  for (genvar j = 0; j < DIM; j++) begin : g_vec
    assign vec[j] = in_comp[j][DATA_WIDTH-1:0];
  end

  mvt_cfg #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    mvt_lane #(
      .DIM        (DIM),
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .coef_row (coef[r]),
      .vec      (vec),
      .res      (lane_res[r]),
      .ovf      (lane_ovf[r])
    );
  end

  mvt_merge #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk      (clk),
    .ctrl     (ctrl),
    .lane_res (lane_res),
    .lane_ovf (lane_ovf),
    .res      (res_out.data)
  );

  // Input back-pressure only appears when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !vec_in.ready |-> &valid)
    else $error("input stalled while the pipeline has a free stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (vec_in.valid && vec_in.ready) |=> valid[0])
    else $error("accepted vector did not enter the multiply stage");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_out.valid) |-> $past(valid[NS-2]))
    else $error("result became valid without an item in the saturate stage");

  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.data.overflow) |->
      (res_out.data.out_x == OUT_MAX || res_out.data.out_x == OUT_MIN ||
       res_out.data.out_y == OUT_MAX || res_out.data.out_y == OUT_MIN ||
       res_out.data.out_z == OUT_MAX || res_out.data.out_z == OUT_MIN ||
       res_out.data.out_w == OUT_MAX || res_out.data.out_w == OUT_MIN))
    else $error("overflow flagged but no component is saturated");

endmodule
